// ===== sv/sm4_pkg.sv =====
// ----------------------------------------------------------------------------
// sm4_pkg
// shared types, constants and round functions of the sm4 block cipher
// ----------------------------------------------------------------------------
package sm4_pkg;

    localparam int ROUNDS    = 32;
    localparam int RND_W     = $clog2(ROUNDS);
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 1'b1;

    localparam logic [31:0] FK0 = 32'hA3B1BAC6;
    localparam logic [31:0] FK1 = 32'h56AA3350;
    localparam logic [31:0] FK2 = 32'h677D9197;
    localparam logic [31:0] FK3 = 32'hB27022DC;
    localparam logic [31:0] CK_STEP = 32'h00070E15;

    typedef struct packed {
        logic [63:0] plaintext_high;
        logic [63:0] plaintext_low;
    } t_in_item;

    typedef struct packed {
        logic [63:0] ciphertext_high;
        logic [63:0] ciphertext_low;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic           key_load;
        logic           key_step;
        logic           data_load;
        logic           data_step;
        logic [RND_W-1:0] round;
    } t_dp_cmd;

    localparam logic [7:0] SBOX [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    function automatic logic [31:0] tau(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] w, input int n);
        return (w << n) | (w >> (32 - n));
    endfunction

    function automatic logic [31:0] mix_data(input logic [31:0] w);
        return w ^ rotl(w, 2) ^ rotl(w, 10) ^ rotl(w, 18) ^ rotl(w, 24);
    endfunction

    function automatic logic [31:0] mix_key(input logic [31:0] w);
        return w ^ rotl(w, 13) ^ rotl(w, 23);
    endfunction

    // byte j of ck(i) is 28*i + 7*j mod 256, each byte wraps on its own
    function automatic logic [31:0] round_const(input logic [RND_W-1:0] i);
        logic [7:0] b;
        b = 8'(i) * 8'd28;
        return {b + CK_STEP[31:24], b + CK_STEP[23:16],
                b + CK_STEP[15:8],  b + CK_STEP[7:0]};
    endfunction

endpackage

// ===== sv/sm4_ram.sv =====
// ----------------------------------------------------------------------------
// sm4_ram
// generic single-port-write ram with registered read
// ----------------------------------------------------------------------------
module sm4_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== sv/sm4_ctrl.sv =====
// ----------------------------------------------------------------------------
// sm4_ctrl
// sequencer for key expansion and block rounds
// ----------------------------------------------------------------------------
module sm4_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_key_wr,
    output logic              o_busy,
    output logic              o_done,
    output sm4_pkg::t_dp_cmd  o_cmd
);
    import sm4_pkg::*;

    typedef enum logic [4:0] {
        S_KEYLOAD = 5'b00001,
        S_KEY     = 5'b00010,
        S_IDLE    = 5'b00100,
        S_FETCH   = 5'b01000,
        S_RUN     = 5'b10000
    } t_state;

    t_state           r_state, n_state;
    logic [RND_W-1:0] r_round, n_round;
    logic             r_done, n_done;

    always_comb begin
        n_state = r_state;
        n_round = r_round;
        n_done  = 1'b0;
        o_cmd   = '0;
        o_cmd.round = r_round;
        unique case (r_state)
            S_KEYLOAD: begin
                o_cmd.key_load = 1'b1;
                n_round = '0;
                n_state = S_KEY;
            end
            S_KEY: begin
                o_cmd.key_step = 1'b1;
                n_round = r_round + 1'b1;
                if (r_round == RND_W'(ROUNDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                n_round = '0;
                if (i_key_wr) begin
                    n_state = S_KEYLOAD;
                end else if (i_start) begin
                    o_cmd.data_load = 1'b1;
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                // ram read of round key 0 in flight
                n_round = r_round + 1'b1;
                n_state = S_RUN;
            end
            S_RUN: begin
                o_cmd.data_step = 1'b1;
                n_round = r_round + 1'b1;
                if (r_round == '0) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (i_key_wr && r_state != S_IDLE) begin
            n_state = S_KEYLOAD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_KEYLOAD;
            r_round <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
            r_done  <= n_done;
        end
    end

    assign o_busy = (r_state != S_IDLE) || i_key_wr;
    assign o_done = r_done;
endmodule

// ===== sv/sm4_dp.sv =====
// ----------------------------------------------------------------------------
// sm4_dp
// shared round datapath, key registers and round key store
// ----------------------------------------------------------------------------
module sm4_dp (
    input  logic                             i_clk,
    input  sm4_pkg::t_dp_cmd                 i_cmd,
    input  logic                             i_cfg_we,
    input  logic [sm4_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [63:0]                      i_cfg_data,
    input  logic                             i_rst_n,
    input  sm4_pkg::t_in_item                i_item,
    output sm4_pkg::t_out_item               o_item
);
    import sm4_pkg::*;

    logic [63:0]  r_key_high, r_key_low;
    logic [127:0] r_x;
    logic [31:0]  rk;
    logic [31:0]  mix_in, sub, nw;
    logic         is_key;

    assign is_key = i_cmd.key_step;
    assign mix_in = r_x[95:64] ^ r_x[63:32] ^ r_x[31:0]
                  ^ (is_key ? round_const(i_cmd.round) : rk);
    assign sub    = tau(mix_in);
    assign nw     = r_x[127:96] ^ (is_key ? mix_key(sub) : mix_data(sub));

    sm4_ram #(.WIDTH(32), .DEPTH(ROUNDS)) u_rk (
        .i_clk   (i_clk),
        .i_we    (i_cmd.key_step),
        .i_waddr (i_cmd.round),
        .i_wdata (nw),
        .i_raddr (i_cmd.round),
        .o_rdata (rk)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.key_load) begin
            r_x <= {r_key_high[63:32] ^ FK0, r_key_high[31:0] ^ FK1,
                    r_key_low[63:32] ^ FK2, r_key_low[31:0] ^ FK3};
        end else if (i_cmd.data_load) begin
            r_x <= {i_item.plaintext_high, i_item.plaintext_low};
        end else if (i_cmd.key_step || i_cmd.data_step) begin
            r_x <= {r_x[95:0], nw};
        end
    end

    assign o_item.ciphertext_high = {r_x[31:0], r_x[63:32]};
    assign o_item.ciphertext_low  = {r_x[95:64], r_x[127:96]};
endmodule

// ===== sv/sm4_block_encrypt.sv =====
// ----------------------------------------------------------------------------
// sm4_block_encrypt
// sm4 encryption of one 128-bit block per start, round keys held in a ram
// ----------------------------------------------------------------------------
// a start fetches round key 0, then the rounds run one per cycle until o_done
// a new block is taken only when idle, once the shared round unit has finished the last one
// a key write or reset runs a key expansion, busy meanwhile
// results show for one cycle on o_done; the receiver cannot stall
module sm4_block_encrypt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  sm4_pkg::t_in_item             i_item,
    output logic                          o_done,
    output sm4_pkg::t_out_item            o_item,
    input  logic                          i_cfg_we,
    input  logic [sm4_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]                   i_cfg_data
);
    import sm4_pkg::*;

    t_dp_cmd cmd;
    logic    key_wr;

    // writes to any listed register restart expansion
    assign key_wr = i_cfg_we;

    sm4_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_key_wr (key_wr),
        .o_busy   (busy),
        .o_done   (o_done),
        .o_cmd    (cmd)
    );

    sm4_dp u_dp (
        .i_clk      (i_clk),
        .i_cmd      (cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .o_item     (o_item)
    );
endmodule
